// ----- sv/mva_pkg.sv -----
package mva_pkg;

    localparam int VOICES   = 8;
    localparam int CC_SLOTS = 4;
    localparam int VOICE_W  = $clog2(VOICES);
    localparam int CNT_W    = $clog2(VOICES + 1);

    // Status nibbles.
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hB;

    // Controllers that release every voice when sent with a value of zero.
    localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_MODE_LO       = 7'd123;
    localparam logic [6:0] CC_MODE_HI       = 7'd127;

    // Configuration register indexes.
    localparam logic [2:0] REG_ACTIVE = 3'd0;
    localparam logic [2:0] REG_SLOT0  = 3'd1;
    localparam logic [2:0] REG_SLOT1  = 3'd2;
    localparam logic [2:0] REG_SLOT2  = 3'd3;
    localparam logic [2:0] REG_SLOT3  = 3'd4;

    localparam logic [3:0] ACTIVE_RESET = 4'd8;
    localparam logic [7:0] SLOT_RESET   = 8'd128;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ON   = 2'd1,
        OP_OFF  = 2'd2,
        OP_CTRL = 2'd3
    } t_op;

    // One voice entry as it is kept in the voice memory.
    typedef struct packed {
        logic        gate;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] start_frame;
    } t_voice;

    // Pitch of the lowest octave in Q6.26 Hz, one entry per semitone.
    localparam logic [31:0] SEMI_Q26 [12] = '{
        32'd1097337155, 32'd1162588218, 32'd1231719311, 32'd1304961152,
        32'd1382558180, 32'd1464769368, 32'd1551869087, 32'd1644148025,
        32'd1741914154, 32'd1845493760, 32'd1955232530, 32'd2071496706
    };

    // Pitch of a MIDI note in Q15.16 Hz, rounded half up.
    function automatic logic [30:0] pitch_q16(input logic [6:0] key);
        logic [3:0]  oct;
        logic [6:0]  semi;
        logic [42:0] v;
        oct = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (key >= 7'(12 * i)) begin
                oct = 4'(i);
            end
        end
        semi = key - 7'(7'(oct) * 7'd12);
        v    = (43'(SEMI_Q26[semi[3:0]]) << oct) + 43'd512;
        return v[40:10];
    endfunction

endpackage

// ----- sv/midi_voice_allocator.sv -----
// Note-on and note-off search the active voices: one voice memory read per cycle, a registered
// read stage, closing the search, then writing back and loading the result. A controller or
// an ignored status loads its result directly, and an all-notes-off controller first clears
// every voice. Loading waits while the result register holds a result that is not taken.
// One item is in flight at a time; the next is taken the cycle after its result is loaded.
// Reset (synchronous, active low) clears all voices, sets 8 active voices and unmaps all slots.
module midi_voice_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input items. i_s_tdata, from bit 0: status_byte[7:0], key_or_controller[14:8],
    // amount[21:15], event_frame[53:22], zero fill [55:54].
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,

    // Results. o_m_tdata, from bit 0: voice_num[2:0], voice_started[3],
    // voice_released[4], all_released[5], note[12:6], velocity[19:13],
    // frequency_q16[50:20], cc_stored[51], cc_slot[53:52], cc_value[60:54],
    // zero fill [63:61].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mva_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_PUT   = 4'b1000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [3:0] r_active;
    logic [7:0] r_cc_map [4];

    // The item being worked on.
    t_op         r_op;
    logic        r_all_off;
    logic [6:0]  r_key;
    logic [6:0]  r_amt;
    logic [31:0] r_frame;

    // Read sequencing: r_rd_idx counts reads issued, r_ev_* marks the entry whose
    // data leaves the memory in this cycle.
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_ev_vld;
    logic [VOICE_W-1:0] r_ev_idx;

    // Oldest-voice search.
    logic [31:0]        r_best_age;
    logic [VOICE_W-1:0] r_best;
    logic [31:0]        r_free_age;
    logic [VOICE_W-1:0] r_best_free;
    logic               r_have_free;

    // Note-off search.
    logic               r_found;
    logic [VOICE_W-1:0] r_hit_idx;
    t_voice             r_hit_data;

    // Entries never written since reset read as all zero.
    logic [VOICES-1:0] r_valid;

    // Result register.
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic               ram_we;
    logic [VOICE_W-1:0] ram_waddr;
    t_voice             ram_wdata;
    logic [$bits(t_voice)-1:0] ram_rdata;
    t_voice             rd_entry;

    logic [CNT_W-1:0] n_used;
    logic [CNT_W-1:0] scan_len;
    logic             issue;
    logic             in_fire;
    logic             put_fire;
    logic             cfg_wr;
    logic [31:0]      age;

    t_op              in_op;
    logic             in_all_off;

    logic             cc_hit;
    logic [1:0]       cc_slot;
    logic [VOICE_W-1:0] chosen;
    logic [63:0]      n_out_data;

    mva_ram #(
        .WIDTH ($bits(t_voice)),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[VOICE_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign put_fire   = (r_state == S_PUT) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Active voice count, with zero acting as one and large values as the full table.
    always_comb begin
        if (r_active == 4'd0) begin
            n_used = CNT_W'(1);
        end else if (32'(r_active) > VOICES) begin
            n_used = CNT_W'(VOICES);
        end else begin
            n_used = CNT_W'(r_active);
        end
    end

    // Note searches cover the active voices; the all-notes-off pass covers every voice.
    assign scan_len = (r_state == S_SWEEP) ? CNT_W'(VOICES) : n_used;
    assign issue    = ((r_state == S_SCAN) || (r_state == S_SWEEP)) && (r_rd_idx < scan_len);

    assign rd_entry = r_valid[r_ev_idx] ? t_voice'(ram_rdata) : '0;
    assign age      = r_frame - rd_entry.start_frame;

    // Decode of the incoming message.
    always_comb begin
        case (i_s_tdata[7:4])
            ST_NOTE_ON:  in_op = OP_ON;
            ST_NOTE_OFF: in_op = OP_OFF;
            ST_CTRL:     in_op = OP_CTRL;
            default:     in_op = OP_NONE;
        endcase
        in_all_off = (i_s_tdata[21:15] == 7'd0) &&
                     (i_s_tdata[14:8] inside {CC_ALL_SOUND_OFF, [CC_MODE_LO:CC_MODE_HI]});
    end

    // Controller slot match; the highest matching slot wins.
    always_comb begin
        cc_hit  = 1'b0;
        cc_slot = 2'd0;
        for (int k = 0; k < CC_SLOTS; k++) begin
            if (r_cc_map[k] == {1'b0, r_key}) begin
                cc_hit  = 1'b1;
                cc_slot = 2'(k);
            end
        end
    end

    assign chosen = r_have_free ? r_best_free : r_best;

    // Voice memory writes: the cleared entries of the all-notes-off pass, or the
    // started or released voice when the result is loaded.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ev_idx;
        ram_wdata = rd_entry;
        if (r_state == S_SWEEP) begin
            ram_we             = r_ev_vld;
            ram_wdata.gate     = 1'b0;
            ram_wdata.velocity = 7'd0;
        end else if (put_fire && (r_op == OP_ON)) begin
            ram_we                = 1'b1;
            ram_waddr             = chosen;
            ram_wdata.gate        = 1'b1;
            ram_wdata.note        = r_key;
            ram_wdata.velocity    = r_amt;
            ram_wdata.start_frame = r_frame;
        end else if (put_fire && (r_op == OP_OFF) && r_found) begin
            ram_we         = 1'b1;
            ram_waddr      = r_hit_idx;
            ram_wdata      = r_hit_data;
            ram_wdata.gate = 1'b0;
        end
    end

    // Result fields; those that do not apply to the message stay zero.
    always_comb begin
        n_out_data = '0;
        case (r_op)
            OP_ON: begin
                n_out_data[2:0]   = 3'(chosen);
                n_out_data[3]     = 1'b1;
                n_out_data[12:6]  = r_key;
                n_out_data[19:13] = r_amt;
                n_out_data[50:20] = pitch_q16(r_key);
            end
            OP_OFF: begin
                if (r_found) begin
                    n_out_data[2:0]  = 3'(r_hit_idx);
                    n_out_data[4]    = 1'b1;
                    n_out_data[12:6] = r_key;
                end
            end
            OP_CTRL: begin
                n_out_data[5] = r_all_off;
                if (cc_hit) begin
                    n_out_data[51]    = 1'b1;
                    n_out_data[53:52] = cc_slot;
                    n_out_data[60:54] = r_amt;
                end
            end
            default: n_out_data = '0;
        endcase
    end

    // Configuration reads.
    always_comb begin
        case (paddr[4:2])
            REG_ACTIVE: prdata = {28'd0, r_active};
            REG_SLOT0:  prdata = {24'd0, r_cc_map[0]};
            REG_SLOT1:  prdata = {24'd0, r_cc_map[1]};
            REG_SLOT2:  prdata = {24'd0, r_cc_map[2]};
            REG_SLOT3:  prdata = {24'd0, r_cc_map[3]};
            default:    prdata = 32'd0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
            for (int k = 0; k < 4; k++) begin
                r_cc_map[k] <= SLOT_RESET;
            end
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_ACTIVE: r_active    <= pwdata[3:0];
                REG_SLOT0:  r_cc_map[0] <= pwdata[7:0];
                REG_SLOT1:  r_cc_map[1] <= pwdata[7:0];
                REG_SLOT2:  r_cc_map[2] <= pwdata[7:0];
                REG_SLOT3:  r_cc_map[3] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_ev_vld    <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            // A new result may be loaded in the same cycle as the old one leaves.
            if (put_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    r_rd_idx <= '0;
                    r_ev_vld <= 1'b0;
                    if (in_fire) begin
                        if ((in_op == OP_ON) || (in_op == OP_OFF)) begin
                            r_state <= S_SCAN;
                        end else if ((in_op == OP_CTRL) && in_all_off) begin
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_PUT;
                        end
                    end
                end
                S_SCAN, S_SWEEP: begin
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                    r_ev_vld <= issue;
                    r_ev_idx <= r_rd_idx[VOICE_W-1:0];
                    if (!issue && !r_ev_vld) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (put_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item fields and search results.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op        <= in_op;
            r_all_off   <= in_all_off;
            r_key       <= i_s_tdata[14:8];
            r_amt       <= i_s_tdata[21:15];
            r_frame     <= i_s_tdata[53:22];
            r_best_age  <= '0;
            r_best      <= '0;
            r_free_age  <= '0;
            r_best_free <= '0;
            r_have_free <= 1'b0;
            r_found     <= 1'b0;
            r_hit_idx   <= '0;
        end else if ((r_state == S_SCAN) && r_ev_vld) begin
            // An age of zero never wins, so voice 0 is the default choice.
            if (age > r_best_age) begin
                r_best_age <= age;
                r_best     <= r_ev_idx;
            end
            if (!rd_entry.gate && (age > r_free_age)) begin
                r_free_age  <= age;
                r_best_free <= r_ev_idx;
                r_have_free <= 1'b1;
            end
            // Note-off takes the lowest-numbered gated voice holding the note.
            if (!r_found && rd_entry.gate && (rd_entry.note == r_key)) begin
                r_found    <= 1'b1;
                r_hit_idx  <= r_ev_idx;
                r_hit_data <= rd_entry;
            end
        end
        if (put_fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- sv/mva_ram.sv -----
module mva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
